// ----- rtl/core/phd_pkg.sv -----
// Shared types, widths, codes and defaults of the PI heater drive.
`timescale 1ns / 1ps

package phd_pkg;

   // Field widths
   localparam int TEMP_W     = 12;
   localparam int TIME_W     = 32;
   localparam int GAIN_W     = 24;
   localparam int ERR_W      = TEMP_W + 1;
   localparam int DRIVE_W    = 14;
   localparam int CLAMP_W    = 2;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 16;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = GAIN_W;
   localparam logic [CSR_IDX_W-1:0] CSR_SETPOINT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KP_GAIN  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KI_GAIN  = 2'd2;

   localparam logic signed [TEMP_W-1:0] SETPOINT_RST = 12'sd375;
   localparam logic [GAIN_W-1:0]        KP_GAIN_RST  = 24'd65536;
   localparam logic [GAIN_W-1:0]        KI_GAIN_RST  = 24'd0;

   // Clamp codes
   localparam logic [CLAMP_W-1:0] CLAMP_NONE = 2'd0;
   localparam logic [CLAMP_W-1:0] CLAMP_MAX  = 2'd1;
   localparam logic [CLAMP_W-1:0] CLAMP_ZERO = 2'd2;

   // Parameter defaults
   localparam int FRAC_BITS_DEF      = 16;
   localparam int DRIVE_MAX_DEF      = 10000;
   localparam int INTEGRAL_WIDTH_DEF = 48;

   // Shared multiplier
   localparam int MUL_A_W = GAIN_W + 1;
   localparam int MUL_B_W = TIME_W + 1;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int MAG_W   = 64;
   localparam int TOTAL_W = 64;
   localparam int KPE_W   = GAIN_W + ERR_W + 1;
   localparam int LO_W    = GAIN_W + TIME_W;

   typedef logic [1:0] mul_sel_type;
   localparam mul_sel_type MUL_INC   = 2'd0;
   localparam mul_sel_type MUL_KP    = 2'd1;
   localparam mul_sel_type MUL_KI_LO = 2'd2;
   localparam mul_sel_type MUL_KI_HI = 2'd3;

   typedef struct packed {
      logic        ld_accept;
      mul_sel_type mul_sel;
      logic        ld_integ;
      logic        ld_kp;
      logic        ld_lo;
      logic        ld_pm;
      logic        ld_total;
      logic        ld_out;
   } ctrl_type;

endpackage

// ----- rtl/core/phd_mul.sv -----
// Shared signed multiplier with operand select and registered product.
`timescale 1ns / 1ps

module phd_mul (
   input  logic                                clock,
   input  phd_pkg::mul_sel_type                mul_sel,
   input  logic signed [phd_pkg::ERR_W-1:0]    err,
   input  logic [phd_pkg::TIME_W-1:0]          dt,
   input  logic [phd_pkg::GAIN_W-1:0]          kp_gain,
   input  logic [phd_pkg::GAIN_W-1:0]          ki_gain,
   input  logic [phd_pkg::MAG_W-1:0]           mag,
   output logic signed [phd_pkg::PROD_W-1:0]   prod
);
   import phd_pkg::*;

   logic signed [MUL_A_W-1:0] op_a;
   logic signed [MUL_B_W-1:0] op_b;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [PROD_W-1:0]  prod_in;

   always_comb begin
      unique case (mul_sel)
         MUL_INC: begin
            op_a = MUL_A_W'(err);
            op_b = $signed({1'b0, dt});
         end
         MUL_KP: begin
            op_a = $signed({1'b0, kp_gain});
            op_b = MUL_B_W'(err);
         end
         MUL_KI_LO: begin
            op_a = $signed({1'b0, ki_gain});
            op_b = $signed({1'b0, mag[TIME_W-1:0]});
         end
         default: begin
            op_a = $signed({1'b0, ki_gain});
            op_b = $signed({1'b0, mag[MAG_W-1:TIME_W]});
         end
      endcase
   end

   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ----- rtl/core/phd_seq.sv -----
// Sequencer that steps one sample through the shared multiplier and adders.
`timescale 1ns / 1ps

module phd_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output phd_pkg::ctrl_type ctrl
);
   import phd_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_INC   = 3'd1;
   localparam logic [2:0] ST_INTEG = 3'd2;
   localparam logic [2:0] ST_KILO  = 3'd3;
   localparam logic [2:0] ST_KIHI  = 3'd4;
   localparam logic [2:0] ST_PM    = 3'd5;
   localparam logic [2:0] ST_TOTAL = 3'd6;
   localparam logic [2:0] ST_DONE  = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       valid_ff, valid_in;

   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      ctrl.mul_sel = MUL_INC;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               ctrl.ld_accept = 1'b1;
               state_in = ST_INC;
            end
         end
         ST_INC: begin
            ctrl.mul_sel = MUL_INC;
            state_in = ST_INTEG;
         end
         ST_INTEG: begin
            ctrl.ld_integ = 1'b1;
            ctrl.mul_sel  = MUL_KP;
            state_in = ST_KILO;
         end
         ST_KILO: begin
            ctrl.ld_kp   = 1'b1;
            ctrl.mul_sel = MUL_KI_LO;
            state_in = ST_KIHI;
         end
         ST_KIHI: begin
            ctrl.ld_lo   = 1'b1;
            ctrl.mul_sel = MUL_KI_HI;
            state_in = ST_PM;
         end
         ST_PM: begin
            ctrl.ld_pm = 1'b1;
            state_in = ST_TOTAL;
         end
         ST_TOTAL: begin
            ctrl.ld_total = 1'b1;
            state_in = ST_DONE;
         end
         default: begin
            // hold until the output register is free
            if (!valid_ff || rsp_tready) begin
               ctrl.ld_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (rsp_tready) begin
         valid_in = 1'b0;
      end
      if (ctrl.ld_out) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = valid_ff;

endmodule

// ----- rtl/core/pi_heater_drive.sv -----
// Top level of the PI heater drive: registers, integral state and result stage.
`timescale 1ns / 1ps

// PI heater drive with integral reset on negative error.
// Input channel req_*: one sample per transfer, temperature in tenths of a
// degree and a millisecond timestamp. Result channel rsp_*: one drive value
// per sample plus a clamp code in tuser (none, at maximum, at zero).
// Configuration port csr_*: setpoint, kp and ki gains; write only while idle.
// A sample steps through the sequencer states up to the output register,
// and no new sample is taken before that. One 25x33 multiplier is shared for
// error*elapsed, kp*error and the two halves of ki*integral, with further
// steps for the integral update, the saturating sum and the total.
// req_tready is high only while the sequencer is idle. A finished result sits
// in the output register; the next sample is taken meanwhile, and its result
// waits in the last step until the receiver takes the earlier one.
// Reset clears the integral and the stored timestamp, loads the register
// defaults and empties the output register. No clearing pass is needed.

module pi_heater_drive #(
   parameter int FRAC_BITS      = phd_pkg::FRAC_BITS_DEF,
   parameter int DRIVE_MAX      = phd_pkg::DRIVE_MAX_DEF,
   parameter int INTEGRAL_WIDTH = phd_pkg::INTEGRAL_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [11:0] temperature_tenths, [43:12] now_ms, [47:44] zero
   input  logic [phd_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [13:0] drive, [15:14] zero
   output logic [phd_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // [1:0] clamp_state
   output logic [phd_pkg::CLAMP_W-1:0]         rsp_tuser,
   input  logic                                csr_wen,
   input  logic [phd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [phd_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import phd_pkg::*;

   localparam int SUM_W = MAG_W + 2;
   localparam logic [SUM_W-1:0] INT_HI =
      (SUM_W'(1) << (INTEGRAL_WIDTH - 1)) - SUM_W'(1);
   localparam logic [TOTAL_W-1:0] PROD_LIMIT = TOTAL_W'(1) << 62;
   localparam logic [TOTAL_W-1:0] DRIVE_LIMIT = TOTAL_W'(DRIVE_MAX);

   ctrl_type ctrl;

   // configuration registers
   logic signed [TEMP_W-1:0] setpoint_ff;
   logic [GAIN_W-1:0]        kp_ff;
   logic [GAIN_W-1:0]        ki_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff <= SETPOINT_RST;
         kp_ff       <= KP_GAIN_RST;
         ki_ff       <= KI_GAIN_RST;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_SETPOINT: setpoint_ff <= $signed(csr_wdata[TEMP_W-1:0]);
            CSR_KP_GAIN:  kp_ff       <= csr_wdata;
            CSR_KI_GAIN:  ki_ff       <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sample intake
   logic signed [TEMP_W-1:0] temp_in;
   logic [TIME_W-1:0]        now_in;
   logic signed [ERR_W-1:0]  err_ff, err_in;
   logic [TIME_W-1:0]        dt_ff, dt_in;
   logic [TIME_W-1:0]        prev_ff;

   assign temp_in = $signed(req_tdata[TEMP_W-1:0]);
   assign now_in  = req_tdata[TEMP_W +: TIME_W];
   assign err_in  = ERR_W'(temp_in) - ERR_W'(setpoint_ff);
   assign dt_in   = now_in - prev_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
      end else if (ctrl.ld_accept) begin
         prev_ff <= now_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.ld_accept) begin
         err_ff <= err_in;
         dt_ff  <= dt_in;
      end
   end

   // shared multiplier
   logic signed [PROD_W-1:0]      prod;
   logic [INTEGRAL_WIDTH-1:0]     integ_ff, integ_in;
   logic [MAG_W-1:0]              mag;

   assign mag = MAG_W'(integ_ff);

   phd_mul u_mul (
      .clock   (clock),
      .mul_sel (ctrl.mul_sel),
      .err     (err_ff),
      .dt      (dt_ff),
      .kp_gain (kp_ff),
      .ki_gain (ki_ff),
      .mag     (mag),
      .prod    (prod)
   );

   // integral: never negative, since a negative error clears it
   logic [SUM_W-1:0] integ_sum;

   assign integ_sum = SUM_W'(integ_ff) + SUM_W'(prod[PROD_W-2:0]);

   always_comb begin
      priority if (err_ff[ERR_W-1]) begin
         integ_in = '0;
      end else if (integ_sum > INT_HI) begin
         integ_in = INT_HI[INTEGRAL_WIDTH-1:0];
      end else begin
         integ_in = integ_sum[INTEGRAL_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff <= '0;
      end else if (ctrl.ld_integ) begin
         integ_ff <= integ_in;
      end
   end

   // partial products and the saturated integral term
   logic signed [KPE_W-1:0]  kpe_ff;
   logic [LO_W-1:0]          lo_ff;
   logic [TOTAL_W-1:0]       pm_ff, pm_in, pm_sum;
   logic                     pm_sat;
   logic signed [TOTAL_W-1:0] total_ff, total_in;

   assign pm_sat = |prod[PROD_W-1:30];
   assign pm_sum = TOTAL_W'({prod[29:0], {TIME_W{1'b0}}}) + TOTAL_W'(lo_ff);
   assign pm_in  = (pm_sat || pm_sum > PROD_LIMIT) ? PROD_LIMIT : pm_sum;
   assign total_in = TOTAL_W'(kpe_ff) + $signed(pm_ff);

   always_ff @(posedge clock) begin
      if (ctrl.ld_kp) begin
         kpe_ff <= prod[KPE_W-1:0];
      end
      if (ctrl.ld_lo) begin
         lo_ff <= prod[LO_W-1:0];
      end
      if (ctrl.ld_pm) begin
         pm_ff <= pm_in;
      end
      if (ctrl.ld_total) begin
         total_ff <= total_in;
      end
   end

   // shift and clamp
   logic [TOTAL_W-1:0]  shifted;
   logic [DRIVE_W-1:0]  drive_in, drive_ff;
   logic [CLAMP_W-1:0]  clamp_in, clamp_ff;

   assign shifted = total_ff >> FRAC_BITS;

   always_comb begin
      priority if (total_ff[TOTAL_W-1]) begin
         drive_in = '0;
         clamp_in = CLAMP_ZERO;
      end else if (shifted > DRIVE_LIMIT) begin
         drive_in = DRIVE_LIMIT[DRIVE_W-1:0];
         clamp_in = CLAMP_MAX;
      end else begin
         drive_in = shifted[DRIVE_W-1:0];
         clamp_in = CLAMP_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.ld_out) begin
         drive_ff <= drive_in;
         clamp_ff <= clamp_in;
      end
   end

   phd_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .ctrl       (ctrl)
   );

   assign rsp_tdata = RSP_DATA_W'(drive_ff);
   assign rsp_tuser = clamp_ff;

endmodule

// ----- verif/pi_heater_drive_test.sv -----
// Self-checking testbench for pi_heater_drive: directed and random samples against a PI model.
`timescale 1ns / 1ps

module pi_heater_drive_test;
   import phd_pkg::*;

   localparam int          FRAC_BITS     = FRAC_BITS_DEF;
   localparam longint      DRIVE_MAX     = DRIVE_MAX_DEF;
   localparam longint      INTEG_HI      = (longint'(1) <<< (INTEGRAL_WIDTH_DEF - 1)) - 1;
   localparam longint      INTEG_LO      = -INTEG_HI - 1;
   localparam logic [71:0] KI_TERM_CAP   = 72'h4000_0000_0000_0000;
   localparam int          SETTLE_CYCLES = 12;
   localparam int          MAX_REPORTS   = 10;
   localparam int          RANDOM_ITEMS  = 700;

   typedef struct packed {
      logic [RSP_DATA_W-1:0] data;
      logic [CLAMP_W-1:0]    clamp;
   } drive_result_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [CLAMP_W-1:0]    rsp_tuser;
   logic                  csr_wen;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // controller state as the block should hold it
   logic signed [TEMP_W-1:0] sp_reg;
   logic [GAIN_W-1:0]        kp_reg;
   logic [GAIN_W-1:0]        ki_reg;
   longint                   integ_acc;
   logic [TIME_W-1:0]        last_stamp;

   drive_result_type  pending_drives[$];
   logic [TIME_W-1:0] stamp_now;
   int  samples_sent = 0;
   int  results_checked = 0;
   int  mismatches = 0;
   int  csr_writes = 0;
   int  seen_none = 0;
   int  seen_max = 0;
   int  seen_zero = 0;
   int  burst_left = 0;
   bit  sender_live = 1'b0;
   int  ready_tick = 0;
   int  stall_run = 0;

   pi_heater_drive uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // receiver: rotate between always ready, random, sparse and long stalls
   always @(negedge clock) begin
      ready_tick++;
      case ((ready_tick / 300) % 4)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2: rsp_tready <= (ready_tick % 5 == 0);
         default: begin
            if (stall_run > 0) begin
               stall_run--;
               rsp_tready <= 1'b0;
            end else begin
               rsp_tready <= 1'b1;
               if ($urandom_range(0, 7) == 0) stall_run = $urandom_range(1, 24);
            end
         end
      endcase
   end

   task automatic report_mismatch(input string what, input longint want, input longint got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
   endtask

   task automatic check_drive(input logic [RSP_DATA_W-1:0] data, input logic [CLAMP_W-1:0] clamp);
      drive_result_type want;
      if (pending_drives.size() == 0) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%0t: result with nothing expected: drive %0d, clamp %0d",
                     $time, data, clamp);
      end else begin
         want = pending_drives.pop_front();
         results_checked++;
         if (data !== want.data) report_mismatch("drive", want.data, data);
         if (clamp !== want.clamp) report_mismatch("clamp state", want.clamp, clamp);
         case (want.clamp)
            CLAMP_NONE: seen_none++;
            CLAMP_MAX:  seen_max++;
            default:    seen_zero++;
         endcase
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_drive(rsp_tdata, rsp_tuser);
   end

   // advance the integral and work out the clamped drive for one sample
   task automatic predict_drive(input logic [TEMP_W-1:0] temp_bits, input logic [TIME_W-1:0] now);
      logic [TIME_W-1:0] elapsed;
      longint            err;
      longint            sum;
      longint            total;
      longint            level;
      logic [63:0]       mag;
      logic [71:0]       ki_prod;
      drive_result_type  res;
      elapsed = now - last_stamp;
      err = longint'($signed(temp_bits)) - longint'(sp_reg);
      sum = integ_acc + err * longint'({32'd0, elapsed});
      if (sum > INTEG_HI) sum = INTEG_HI;
      else if (sum < INTEG_LO) sum = INTEG_LO;
      if (err < 0) sum = 0;
      integ_acc = sum;
      last_stamp = now;

      mag = (sum < 0) ? -sum : sum;
      ki_prod = {48'd0, ki_reg} * {8'd0, mag};
      if (ki_prod > KI_TERM_CAP) ki_prod = KI_TERM_CAP;
      total = longint'({40'd0, kp_reg}) * err;
      if (sum < 0) total -= longint'(ki_prod[63:0]);
      else total += longint'(ki_prod[63:0]);

      res.data = '0;
      if (total < 0) begin
         res.clamp = CLAMP_ZERO;
      end else begin
         level = total >>> FRAC_BITS;
         if (level > DRIVE_MAX) begin
            level = DRIVE_MAX;
            res.clamp = CLAMP_MAX;
         end else begin
            res.clamp = CLAMP_NONE;
         end
         res.data = level[RSP_DATA_W-1:0];
      end
      pending_drives.push_back(res);
   endtask

   // call at a falling edge; valid stays high while a burst lasts
   task automatic send_sample(input logic [TEMP_W-1:0] temp_bits, input logic [TIME_W-1:0] now);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata <= {{(REQ_DATA_W - TEMP_W - TIME_W){1'b0}}, now, temp_bits};
      sender_live = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_drive(temp_bits, now);
      samples_sent++;
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_tvalid <= 1'b0;
         sender_live = 1'b0;
         gap = $urandom_range(1, 12);
         repeat (gap) @(negedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? 80 : $urandom_range(0, 15);
      end
   endtask

   task automatic wait_idle();
      if (sender_live) begin
         req_tvalid <= 1'b0;
         sender_live = 1'b0;
         @(negedge clock);
      end
      while (pending_drives.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_wen <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_wen <= 1'b0;
      case (index)
         CSR_SETPOINT: sp_reg = value[TEMP_W-1:0];
         CSR_KP_GAIN:  kp_reg = value;
         CSR_KI_GAIN:  ki_reg = value;
         default: ;
      endcase
      csr_writes++;
   endtask

   task automatic configure(input logic [TEMP_W-1:0] sp, input logic [GAIN_W-1:0] kp,
                            input logic [GAIN_W-1:0] ki);
      logic [CSR_DATA_W-TEMP_W-1:0] upper;
      wait_idle();
      // the setpoint takes only the low bits; put junk above them
      upper = (CSR_DATA_W - TEMP_W)'($urandom);
      write_reg(CSR_SETPOINT, {upper, sp});
      write_reg(CSR_KP_GAIN, kp);
      write_reg(CSR_KI_GAIN, ki);
   endtask

   task automatic test_after_reset();
      // first sample measures elapsed time from a zero timestamp
      send_sample(12'sd400, 32'd1000);
      send_sample(12'sd375, 32'd1500);
      send_sample(12'sd374, 32'd1501);
      stamp_now = 32'd1501;
   endtask

   task automatic test_field_extremes();
      send_sample(12'h7FF, 32'hFFFF_FFFF);
      // timestamp goes backward: counts as a one-tick wrap
      send_sample(12'h800, 32'd0);
      send_sample(-12'sd500, 32'h8000_0000);
      send_sample(12'sd1500, 32'h8000_0001);
      configure(12'sd375, 24'hFF_FFFF, 24'd0);
      send_sample(12'sd1500, 32'h8000_0002);
      // gain of 1.5 on an error of 3: the half is dropped
      configure(12'sd0, 24'h01_8000, 24'd0);
      send_sample(12'sd3, 32'h8000_0003);
      stamp_now = 32'h8000_0003;
   endtask

   task automatic test_integral_limits();
      int i;
      configure(12'h800, 24'd0, 24'd1);
      // largest error over the longest interval: runs into the integral ceiling
      for (i = 0; i < 10; i++) begin
         stamp_now += 32'hFFFF_FFFF;
         send_sample(12'h7FF, stamp_now);
      end
      configure(12'h800, 24'd0, 24'hFF_FFFF);
      send_sample(12'h7FF, stamp_now);
      // negative error drops the integral
      configure(12'h7FF, 24'd0, 24'hFF_FFFF);
      stamp_now += 32'd7;
      send_sample(12'h800, stamp_now);
      configure(12'h7FF, 24'hFF_FFFF, 24'hFF_FFFF);
      stamp_now += 32'd9;
      send_sample(12'h800, stamp_now);
   endtask

   task automatic test_random_operation(input int n_items);
      int                phase;
      int                i;
      int                spread;
      logic [TEMP_W-1:0] sp_pick;
      logic [TEMP_W-1:0] temp_bits;
      logic [GAIN_W-1:0] kp_pick;
      logic [GAIN_W-1:0] ki_pick;
      for (phase = 0; phase < 7; phase++) begin
         case (phase)
            0: begin
               sp_pick = -12'sd500;
               kp_pick = '0;
               ki_pick = '0;
            end
            1: begin
               sp_pick = 12'sd1500;
               kp_pick = 24'hFF_FFFF;
               ki_pick = 24'hFF_FFFF;
            end
            default: begin
               sp_pick = TEMP_W'($urandom_range(0, 2000) - 500);
               kp_pick = GAIN_W'(($urandom_range(1, 200) << 16) |
                                 $urandom_range(0, 16'hFFFF));
               ki_pick = GAIN_W'(($urandom_range(0, 3) == 0) ? $urandom
                                                             : $urandom_range(0, 3000));
            end
         endcase
         configure(sp_pick, kp_pick, ki_pick);
         spread = $urandom_range(10, 120);
         for (i = 0; i < n_items / 7; i++) begin
            if ($urandom_range(0, 7) == 0) begin
               // noise: any temperature, jumps and repeats in the timestamp
               temp_bits = TEMP_W'($urandom);
               if ($urandom_range(0, 1) == 1) stamp_now = $urandom;
               else stamp_now += $urandom_range(0, 3);
            end else begin
               temp_bits = TEMP_W'(sp_pick + $urandom_range(0, 2 * spread) - spread);
               stamp_now += $urandom_range(1, 2000);
            end
            send_sample(temp_bits, stamp_now);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_wen = 1'b0;
      csr_index = CSR_SETPOINT;
      csr_wdata = '0;
      sp_reg = SETPOINT_RST;
      kp_reg = KP_GAIN_RST;
      ki_reg = KI_GAIN_RST;
      integ_acc = 0;
      last_stamp = '0;
      stamp_now = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_after_reset();
      test_field_extremes();
      test_integral_limits();
      test_random_operation(RANDOM_ITEMS);
      wait_idle();

      $display("Ran %0d samples through %0d register writes; %0d results checked.",
               samples_sent, csr_writes, results_checked);
      $display("Drive in range %0d times, held at maximum %0d, held at zero %0d.",
               seen_none, seen_max, seen_zero);
      if (mismatches == 0)
         $display("pi_heater_drive regression: pass");
      else
         $display("pi_heater_drive regression: fail");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timed out with %0d results outstanding.", pending_drives.size());
      $display("pi_heater_drive regression: fail");
      $finish;
   end

endmodule
